// File: design/bpp_pkg.sv
package bpp_pkg;

  // Widths fixed by the register map and the word fields.
  localparam int unsigned PREC_W    = 5;
  localparam int unsigned GRP_W     = 7;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned IDX_W     = 4;

  localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(3);
  localparam logic [GRP_W-1:0]  GRP_RESET  = GRP_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRECISION  = 1'b0,
    REG_GROUP_SIZE = 1'b1
  } reg_idx_t;

  // Control shared by every cell of the plane chain.
  typedef struct packed {
    logic shift;    // an element is taken this cycle
    logic close;    // that element closes the group
    logic load;     // copy the shifted planes into the drain stages
    logic advance;  // drain stages move one place towards plane 0
  } cell_ctl_t;

endpackage

// File: design/bpp_cell.sv
// One plane: its accumulator and its stage of the drain chain.
module bpp_cell #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpp_pkg::cell_ctl_t    ctl,
  input  logic                  active,
  input  logic                  bit_in,
  input  logic [WORD_BITS-1:0]  drain_in,
  output logic [WORD_BITS-1:0]  drain_out
);

  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] acc_nxt;
  logic [WORD_BITS-1:0] acc_shifted;
  logic [WORD_BITS-1:0] drain_r;
  logic [WORD_BITS-1:0] drain_nxt;

  // Planes outside the current precision hold still.
  assign acc_shifted = active ? {acc_r[WORD_BITS-2:0], bit_in} : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.shift) begin
      acc_nxt = ctl.close ? '0 : acc_shifted;
    end
  end

  always_comb begin
    drain_nxt = drain_r;
    if (ctl.load) begin
      drain_nxt = acc_shifted;
    end else if (ctl.advance) begin
      drain_nxt = drain_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drain_r <= drain_nxt;
  end

  assign drain_out = drain_r;

endmodule

// File: design/bit_plane_packer.sv
// Channel  Direction  Fields                                        Handshake
// in_      input      element_value[15:0], end_of_data              in_valid / in_ready
// out_     output     plane_word[WORD_BITS-1:0], plane_index[3:0],  out_valid / out_ready
//                     last_of_group
// cfg_     input      index (0 precision, 1 group size), data[6:0]  cfg_we, no wait
//
// One element word is taken per cycle; every active plane shifts at once in its own cell.
// A closing element copies all planes into the drain chain in the same cycle, and the
// group's plane words then leave one per cycle from plane 0 while out_ready is high, the
// chain moving one place towards the output on each accepted word. A group of P planes
// thus gives P output words; input is held off only when a closing element arrives while
// the previous group is still draining and its last word is not leaving in that same
// cycle. Reset is synchronous and active low, clears the planes, the count and the drain
// control, and restores precision 3 and group size 8.
module bit_plane_packer #(
  parameter int unsigned MAX_PRECISION = 16,
  parameter int unsigned WORD_BITS     = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bpp_pkg::ELEM_W-1:0]         in_element_value,
  input  logic                               in_end_of_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [WORD_BITS-1:0]               out_plane_word,
  output logic [bpp_pkg::IDX_W-1:0]          out_plane_index,
  output logic                               out_last_of_group,
  input  logic                               cfg_we,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpp_pkg::CFG_W-1:0]          cfg_data
);

  localparam int unsigned PL_W  = $clog2(MAX_PRECISION + 1);
  localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

  // Configuration registers, written by the user only while the block is quiet; unchecked.
  logic [bpp_pkg::PREC_W-1:0] prec_r;
  logic [bpp_pkg::GRP_W-1:0]  grp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= bpp_pkg::PREC_RESET;
      grp_r  <= bpp_pkg::GRP_RESET;
    end else if (cfg_we) begin
      unique case (bpp_pkg::reg_idx_t'(cfg_index))
        bpp_pkg::REG_PRECISION:  prec_r <= cfg_data[bpp_pkg::PREC_W-1:0];
        bpp_pkg::REG_GROUP_SIZE: grp_r  <= cfg_data[bpp_pkg::GRP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: zero counts as one, large values saturate.
  logic [PL_W-1:0]            planes;
  logic [bpp_pkg::GRP_W-1:0]  grp_act;

  always_comb begin
    if (prec_r == '0) begin
      planes = PL_W'(1);
    end else if (32'(prec_r) > MAX_PRECISION) begin
      planes = PL_W'(MAX_PRECISION);
    end else begin
      planes = PL_W'(prec_r);
    end
  end

  always_comb begin
    if (grp_r == '0) begin
      grp_act = bpp_pkg::GRP_W'(1);
    end else if (32'(grp_r) > WORD_BITS) begin
      grp_act = bpp_pkg::GRP_W'(WORD_BITS);
    end else begin
      grp_act = grp_r;
    end
  end

  // Element count within the current group.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [7:0]       cnt_plus;
  logic             closes;

  assign cnt_plus = 8'(cnt_r) + 8'd1;
  assign closes   = (cnt_plus >= 8'(grp_act)) || in_end_of_data;

  // Drain control: words still to deliver and the plane now at the output.
  logic [PL_W-1:0]             left_r;
  logic [PL_W-1:0]             left_nxt;
  logic [bpp_pkg::IDX_W-1:0]   idx_r;
  logic [bpp_pkg::IDX_W-1:0]   idx_nxt;
  logic                        in_fire;
  logic                        out_fire;
  bpp_pkg::cell_ctl_t          ctl;

  // A closing element needs the drain chain empty, or its last word leaving in this
  // cycle; any other element may enter.
  assign in_ready  = (left_r == '0) || ((left_r == PL_W'(1)) && out_ready) || !closes;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (left_r != '0);
  assign out_fire  = out_valid && out_ready;

  assign ctl.shift   = in_fire;
  assign ctl.close   = closes;
  assign ctl.load    = in_fire && closes;
  assign ctl.advance = out_fire;

  always_comb begin
    cnt_nxt  = cnt_r;
    left_nxt = left_r;
    idx_nxt  = idx_r;
    if (in_fire) begin
      cnt_nxt = closes ? '0 : cnt_plus[CNT_W-1:0];
    end
    if (ctl.load) begin
      left_nxt = planes;
      idx_nxt  = '0;
    end else if (out_fire) begin
      left_nxt = left_r - PL_W'(1);
      idx_nxt  = idx_r + bpp_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      left_r <= '0;
      idx_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // The chain of plane cells. Each drain stage takes its upper neighbour's word
  // as the chain advances; the topmost is fed with zero.
  logic [WORD_BITS-1:0] drain_w [0:MAX_PRECISION];

  assign drain_w[MAX_PRECISION] = '0;

  for (genvar k = 0; k < MAX_PRECISION; k++) begin : g_cell
    logic bit_k;
    logic active_k;

    if (k < bpp_pkg::ELEM_W) begin : g_bit
      assign bit_k = in_element_value[k];
    end else begin : g_zero
      assign bit_k = 1'b0;
    end

    assign active_k = (32'(planes) > k);

    bpp_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .active    (active_k),
      .bit_in    (bit_k),
      .drain_in  (drain_w[k+1]),
      .drain_out (drain_w[k])
    );
  end

  assign out_plane_word    = drain_w[0];
  assign out_plane_index   = idx_r;
  assign out_last_of_group = (left_r == PL_W'(1));

  // A group is only copied into the drain chain once the previous one has left, or
  // as its last word leaves.
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (left_r == '0) || (out_fire && out_last_of_group))
    else $error("drain chain loaded while still busy");

  a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(left_r) <= MAX_PRECISION)
    else $error("drain count beyond the number of planes");

  a_load_sets_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (left_r == $past(planes)) && (idx_r == '0))
    else $error("drain count or plane index wrong after a group closed");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_last_of_group && !ctl.load |=> left_r == '0)
    else $error("words remain after the last word of a group");

endmodule
